@@ rtl/core/throttle_hysteresis_scale_ramp_defines.svh @@
// Assertion helpers for the throttle ramp block; clocked on i_clk, held off in reset.
`ifndef THROTTLE_HYSTERESIS_SCALE_RAMP_DEFINES_SVH
`define THROTTLE_HYSTERESIS_SCALE_RAMP_DEFINES_SVH

// Same-cycle implication.
`define THSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define THSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/thsr_pkg.sv @@
package thsr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DUTY_BITS_DEF   = 16;
    localparam int FRAC_BITS       = 8;
    localparam int THR_BITS        = 12;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [THR_BITS-1:0]      OFF_THR_RST = 12'd0;
    localparam logic [THR_BITS-1:0]      ON_THR_RST  = 12'd4095;
    localparam logic [CFG_DATA_BITS-1:0] GAIN_RST    = 24'd179566;
    localparam logic [CFG_DATA_BITS-1:0] OFFSET_RST  = 24'd650240;
    localparam logic [CFG_DATA_BITS-1:0] STEP_RST    = 24'd256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OFF_THR = 3'd0,
        CFG_ON_THR  = 3'd1,
        CFG_GAIN    = 3'd2,
        CFG_OFFSET  = 3'd3,
        CFG_STEP    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] gain;
        logic [CFG_DATA_BITS-1:0] offset;
    } t_scale_cfg;

endpackage

@@ rtl/core/thsr_target.sv @@
module thsr_target #(
    parameter int SAMPLE_BITS = thsr_pkg::SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = thsr_pkg::DUTY_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]                  i_sample,
    input  thsr_pkg::t_scale_cfg                    i_cfg,
    output logic [DUTY_BITS+thsr_pkg::FRAC_BITS-1:0] o_target
);
    import thsr_pkg::*;

    localparam int RAMP_BITS = DUTY_BITS + FRAC_BITS;
    localparam int PROD_W    = SAMPLE_BITS + CFG_DATA_BITS;
    localparam int SCALED_W  = PROD_W - FRAC_BITS;
    localparam int EXT_W     = (SCALED_W > RAMP_BITS) ? SCALED_W : RAMP_BITS;

    logic [PROD_W-1:0]   product;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] offset_ext;
    logic [SCALED_W-1:0] diff;
    logic [EXT_W-1:0]    diff_ext;
    logic [EXT_W-1:0]    top_ext;

    assign product    = PROD_W'(i_sample) * PROD_W'(i_cfg.gain);
    assign scaled     = product[PROD_W-1:FRAC_BITS];
    assign offset_ext = SCALED_W'(i_cfg.offset);
    assign diff       = (scaled > offset_ext) ? (scaled - offset_ext) : '0;
    assign diff_ext   = EXT_W'(diff);
    assign top_ext    = EXT_W'({RAMP_BITS{1'b1}});
    assign o_target   = (diff_ext > top_ext) ? RAMP_BITS'(top_ext) : RAMP_BITS'(diff_ext);

endmodule

@@ rtl/core/thsr_ramp.sv @@
module thsr_ramp #(
    parameter int DUTY_BITS = thsr_pkg::DUTY_BITS_DEF
) (
    input  logic [DUTY_BITS+thsr_pkg::FRAC_BITS-1:0] i_ramp,
    input  logic [DUTY_BITS+thsr_pkg::FRAC_BITS-1:0] i_target,
    input  logic [thsr_pkg::CFG_DATA_BITS-1:0]       i_step,
    output logic [DUTY_BITS+thsr_pkg::FRAC_BITS-1:0] o_ramp
);
    import thsr_pkg::*;

    localparam int RAMP_BITS = DUTY_BITS + FRAC_BITS;
    localparam int RW = (RAMP_BITS > CFG_DATA_BITS) ? RAMP_BITS : CFG_DATA_BITS;

    logic [RW-1:0] ramp_w;
    logic [RW-1:0] target_w;
    logic [RW-1:0] step_w;
    logic [RW-1:0] gap_up;
    logic [RW-1:0] gap_dn;

    assign ramp_w   = RW'(i_ramp);
    assign target_w = RW'(i_target);
    assign step_w   = RW'(i_step);
    assign gap_up   = target_w - ramp_w;
    assign gap_dn   = ramp_w - target_w;

    always_comb begin
        o_ramp = i_ramp;
        if (target_w > ramp_w) begin
            o_ramp = (gap_up > step_w) ? RAMP_BITS'(ramp_w + step_w) : i_target;
        end else if (target_w < ramp_w) begin
            o_ramp = (gap_dn > step_w) ? RAMP_BITS'(ramp_w - step_w) : i_target;
        end
    end

endmodule

@@ rtl/core/throttle_hysteresis_scale_ramp.sv @@
// Throttle gate and duty ramp. Takes one raw ADC sample per transfer and returns one duty count
// and the hysteresis flag per sample, sustaining one sample per clock while i_out_ready does not stall
// the output. The path from input transfer to result runs through an input register, a register after
// the sample-times-gain multiplier, and the result register, which is also the ramp and flag state,
// so the hysteresis test and the step-limited ramp update close around that register.
// Configuration writes are taken every cycle; make them only while no sample is in flight,
// since gain and offset are read one stage ahead of the thresholds and the ramp step.
`include "throttle_hysteresis_scale_ramp_defines.svh"

module throttle_hysteresis_scale_ramp #(
    parameter int SAMPLE_BITS = thsr_pkg::SAMPLE_BITS_DEF,
    parameter int DUTY_BITS   = thsr_pkg::DUTY_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [SAMPLE_BITS-1:0]               i_raw_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [DUTY_BITS-1:0]                 o_duty_count,
    output logic                                 o_throttle_active,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [thsr_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [thsr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import thsr_pkg::*;

    localparam int RAMP_BITS = DUTY_BITS + FRAC_BITS;
    localparam int CMP_W     = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [THR_BITS-1:0]      r_off_thr;
    logic [THR_BITS-1:0]      r_on_thr;
    logic [CFG_DATA_BITS-1:0] r_gain;
    logic [CFG_DATA_BITS-1:0] r_offset;
    logic [CFG_DATA_BITS-1:0] r_step;

    logic                     r_a_valid;
    logic [SAMPLE_BITS-1:0]   r_a_sample;
    logic                     r_b_valid;
    logic [SAMPLE_BITS-1:0]   r_b_sample;
    logic [RAMP_BITS-1:0]     r_b_target;
    logic                     r_out_valid;
    logic                     r_active;
    logic [RAMP_BITS-1:0]     r_ramp;

    logic                     ready_out;
    logic                     ready_b;
    logic                     a_move;
    logic                     c_load;
    t_scale_cfg               scale_cfg;
    logic [RAMP_BITS-1:0]     scaled_target;
    logic [RAMP_BITS-1:0]     gated_target;
    logic [CMP_W-1:0]         b_sample_ext;
    logic                     n_active;
    logic [RAMP_BITS-1:0]     n_ramp;

    assign ready_out   = !r_out_valid || i_out_ready;
    assign ready_b     = !r_b_valid || ready_out;
    assign o_in_ready  = !r_a_valid || ready_b;
    assign a_move      = r_a_valid && ready_b;
    assign c_load      = r_b_valid && ready_out;
    assign o_cfg_ready = 1'b1;

    assign scale_cfg.gain   = r_gain;
    assign scale_cfg.offset = r_offset;

    thsr_target #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DUTY_BITS   (DUTY_BITS)
    ) u_target (
        .i_sample (r_a_sample),
        .i_cfg    (scale_cfg),
        .o_target (scaled_target)
    );

    assign b_sample_ext = CMP_W'(r_b_sample);

    always_comb begin
        n_active = r_active;
        if (b_sample_ext < CMP_W'(r_off_thr)) begin
            n_active = 1'b0;
        end else if (b_sample_ext > CMP_W'(r_on_thr)) begin
            n_active = 1'b1;
        end
    end

    assign gated_target = n_active ? r_b_target : '0;

    thsr_ramp #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ramp (
        .i_ramp   (r_ramp),
        .i_target (gated_target),
        .i_step   (r_step),
        .o_ramp   (n_ramp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_thr <= OFF_THR_RST;
            r_on_thr  <= ON_THR_RST;
            r_gain    <= GAIN_RST;
            r_offset  <= OFFSET_RST;
            r_step    <= STEP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_OFF_THR: begin
                    r_off_thr <= i_cfg_data[THR_BITS-1:0];
                end
                CFG_ON_THR: begin
                    r_on_thr <= i_cfg_data[THR_BITS-1:0];
                end
                CFG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                CFG_OFFSET: begin
                    r_offset <= i_cfg_data;
                end
                CFG_STEP: begin
                    r_step <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_ramp      <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_out) begin
                r_out_valid <= r_b_valid;
            end
            if (c_load) begin
                r_active <= n_active;
                r_ramp   <= n_ramp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a_sample <= i_raw_sample;
        end
        if (a_move) begin
            r_b_sample <= r_a_sample;
            r_b_target <= scaled_target;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_duty_count      = r_ramp[RAMP_BITS-1:FRAC_BITS];
    assign o_throttle_active = r_active;

    `THSR_ASSERT_NEXT(a_hold_state, !c_load, $stable(r_ramp) && $stable(r_active), "state moved without a transfer")
    `THSR_ASSERT_NOW(a_inactive_no_rise, c_load && !n_active, n_ramp <= r_ramp, "ramp rose while inactive")
    `THSR_ASSERT_NOW(a_zero_step_hold, c_load && (r_step == '0), n_ramp == r_ramp, "ramp moved with zero step")

endmodule
